// ----- rtl/core/sfcrc_pkg.sv -----
// Shared types, constants and the byte-wide CRC-16-CCITT update for the subframe validator.
package sfcrc_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned POS_W     = 8;
    localparam int unsigned START_W   = 10;
    localparam int unsigned REMAIN_W  = 9;
    localparam int unsigned CRC_W     = 16;

    localparam logic [CRC_W-1:0]  CRC_POLY   = 16'h1021;
    localparam logic [CRC_W-1:0]  CRC_INIT   = 16'hFFFF;
    localparam logic [BYTE_W-1:0] END_MARKER = 8'hFF;

    // Result of one word as seen by the output register
    typedef struct packed {
        logic [POS_W-1:0] byte_index;
        logic             frame_end;
        logic             frame_valid;
    } t_walk_status;

    // Fold one byte into the CRC, MSB first, no reflection
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (crc[CRC_W-1]) begin
                crc = {crc[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[CRC_W-2:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// ----- rtl/core/sfcrc_walker.sv -----
// Frame position counter, subframe parser and CRC match tracking.
module sfcrc_walker #(
    parameter int unsigned FRAME_BYTES  = 240,
    parameter int unsigned HEADER_SKIP  = 6,
    parameter int unsigned TAIL_RESERVE = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_advance,
    input  logic [sfcrc_pkg::BYTE_W-1:0] i_byte,
    output sfcrc_pkg::t_walk_status    o_status
);
    import sfcrc_pkg::*;

    localparam logic [START_W-1:0] WALK_LIMIT = START_W'(FRAME_BYTES - TAIL_RESERVE);
    localparam logic [START_W-1:0] FIRST_START = START_W'(HEADER_SKIP);
    localparam logic [POS_W-1:0]   LAST_POS = POS_W'(FRAME_BYTES - 1);

    typedef enum logic [2:0] {
        PH_TYPE,
        PH_LEN,
        PH_PAYLOAD,
        PH_CRCLO,
        PH_CRCHI
    } t_phase;

    logic [POS_W-1:0]    r_pos,        n_pos;
    logic [START_W-1:0]  r_next_start, n_next_start;
    t_phase              r_phase,      n_phase;
    logic [REMAIN_W-1:0] r_remaining,  n_remaining;
    logic [CRC_W-1:0]    r_crc,        n_crc;
    logic [BYTE_W-1:0]   r_crc_lo,     n_crc_lo;
    logic                r_checkable,  n_checkable;
    logic                r_stopped,    n_stopped;
    logic                r_match,      n_match;

    logic                w_last;
    logic [REMAIN_W-1:0] w_len;
    logic [START_W-1:0]  w_end;

    assign w_last = (r_pos >= LAST_POS);
    assign w_len  = {i_byte, 1'b0};
    assign w_end  = START_W'(r_pos) + START_W'(w_len) + START_W'(3);

    // Step the parser by one word, then restart the frame state on its last word
    always_comb begin
        n_pos        = r_pos + POS_W'(1);
        n_next_start = r_next_start;
        n_phase      = r_phase;
        n_remaining  = r_remaining;
        n_crc        = r_crc;
        n_crc_lo     = r_crc_lo;
        n_checkable  = r_checkable;
        n_stopped    = r_stopped;
        n_match      = r_match;

        if (!r_stopped) begin
            unique case (r_phase)
                PH_TYPE: begin
                    if (START_W'(r_pos) == r_next_start) begin
                        if (r_next_start >= WALK_LIMIT || i_byte == END_MARKER) begin
                            n_stopped = 1'b1;
                        end else begin
                            n_phase = PH_LEN;
                        end
                    end
                end
                PH_LEN: begin
                    n_checkable  = (w_end <= WALK_LIMIT);
                    n_next_start = w_end;
                    n_remaining  = w_len;
                    n_crc        = CRC_INIT;
                    n_phase      = (w_len == '0) ? PH_CRCLO : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    n_crc       = crc_byte(r_crc, i_byte);
                    n_remaining = r_remaining - REMAIN_W'(1);
                    if (n_remaining == '0) begin
                        n_phase = PH_CRCLO;
                    end
                end
                PH_CRCLO: begin
                    n_crc_lo = i_byte;
                    n_phase  = PH_CRCHI;
                end
                PH_CRCHI: begin
                    if (r_checkable && r_crc == {i_byte, r_crc_lo}) begin
                        n_match = 1'b1;
                    end
                    n_phase = PH_TYPE;
                end
                default: begin
                    n_phase = PH_TYPE;
                end
            endcase
        end

        // Verdict includes a CRC closed by this very word
        o_status.byte_index  = r_pos;
        o_status.frame_end   = w_last;
        o_status.frame_valid = w_last && n_match;

        if (w_last) begin
            n_pos        = '0;
            n_next_start = FIRST_START;
            n_phase      = PH_TYPE;
            n_remaining  = '0;
            n_crc        = CRC_INIT;
            n_crc_lo     = '0;
            n_checkable  = 1'b0;
            n_stopped    = 1'b0;
            n_match      = 1'b0;
        end
    end

    // Hold parser state, advance on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_next_start <= FIRST_START;
            r_phase      <= PH_TYPE;
            r_remaining  <= '0;
            r_crc        <= CRC_INIT;
            r_crc_lo     <= '0;
            r_checkable  <= 1'b0;
            r_stopped    <= 1'b0;
            r_match      <= 1'b0;
        end else if (i_advance) begin
            r_pos        <= n_pos;
            r_next_start <= n_next_start;
            r_phase      <= n_phase;
            r_remaining  <= n_remaining;
            r_crc        <= n_crc;
            r_crc_lo     <= n_crc_lo;
            r_checkable  <= n_checkable;
            r_stopped    <= n_stopped;
            r_match      <= n_match;
        end
    end

endmodule

// ----- rtl/core/subframe_crc_frame_validator_core.sv -----
// Top level of the subframe CRC frame validator: stream handshake and output register.
//
// Usage:
//   The slave channel takes one frame byte per word, frames of FRAME_BYTES bytes
//   back to back with no framing signal; position is counted internally.
//   The master channel returns every byte unchanged with its index in the frame.
//   tlast marks the last byte of each frame, and tuser on that word is 1 when at
//   least one subframe CRC that ends within the walk limit matched.
//   An accepted word is registered and offered in the following cycle.
//   One word is taken per cycle unless the receiver stalls; the parser and the
//   byte-wide CRC update sit in one stage between the parser and output registers.
//   When the receiver stalls the output register holds its word and the slave
//   side takes a new word only in a cycle where that word is being taken.
//   Reset clears the position counter, the parser and the output valid flag;
//   the first byte after reset is byte 0 of a frame.
//   Invalid frames are passed through; dropping them is left downstream.
module subframe_crc_frame_validator_core #(
    parameter int unsigned FRAME_BYTES  = 240,
    parameter int unsigned HEADER_SKIP  = 6,
    parameter int unsigned TAIL_RESERVE = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] byte_out, [15:8] byte_index
    output logic        o_m_tlast,   // frame_end
    output logic        o_m_tuser    // [0] frame_valid
);
    import sfcrc_pkg::*;

    logic         w_accept;
    t_walk_status w_status;

    logic              r_m_valid;
    logic [BYTE_W-1:0] r_m_byte;
    t_walk_status      r_m_status;

    assign o_s_tready = !r_m_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    sfcrc_walker #(
        .FRAME_BYTES  (FRAME_BYTES),
        .HEADER_SKIP  (HEADER_SKIP),
        .TAIL_RESERVE (TAIL_RESERVE)
    ) u_walker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_accept),
        .i_byte    (i_s_tdata),
        .o_status  (w_status)
    );

    // Track output word occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_accept) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    // Load output payload on accept
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_m_byte   <= i_s_tdata;
            r_m_status <= w_status;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {r_m_status.byte_index, r_m_byte};
    assign o_m_tlast  = r_m_status.frame_end;
    assign o_m_tuser  = r_m_status.frame_valid;

endmodule

// ----- rtl/core/sfcrc_checker.sv -----
// Port-level assertions for the subframe CRC frame validator, bound to the top level.
module sfcrc_checker #(
    parameter int unsigned FRAME_BYTES = 240
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [7:0]  i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic        o_m_tlast,
    input logic        o_m_tuser
);
    localparam logic [7:0] LAST_INDEX = 8'(FRAME_BYTES - 1);

    // Hold a stalled output word
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("stalled output word changed");

    // An empty output stage never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input blocked while output stage empty");

    // Frame end flag sits exactly on the last index
    a_last_on_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == (o_m_tdata[15:8] == LAST_INDEX)))
        else $error("tlast does not match byte index");

    // Verdict appears only at frame end
    a_verdict_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast)
        else $error("frame verdict away from frame end");

    // Accepted input word shows up at the output next cycle
    a_pass_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> o_m_tvalid && o_m_tdata[7:0] == $past(i_s_tdata))
        else $error("input byte not passed through");

endmodule

bind subframe_crc_frame_validator_core sfcrc_checker #(
    .FRAME_BYTES (FRAME_BYTES)
) u_sfcrc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);
